FILE: design/sorted_insert_priority_queue_assert.svh
// Assertion macros for the sorted-insert priority queue.
// Expects clk and rst_n in scope at the point of use.
`ifndef SORTED_INSERT_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define SIPQ_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication outside reset.
`define SIPQ_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: design/sipq_pkg.sv
// Shared types and codes for the sorted-insert priority queue.
// No dependencies; imported by sipq_store and the top level.
package sipq_pkg;

    localparam int COUNT_W = 5;
    localparam int DATA_W  = 32;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    typedef struct packed {
        logic                     op;
        logic signed [DATA_W-1:0] item_value;
        logic signed [DATA_W-1:0] item_rank;
    } in_item_t;

    typedef struct packed {
        logic                      done_ok;
        logic signed [DATA_W-1:0]  removed_value;
        logic        [COUNT_W-1:0] entry_count;
        logic                      is_empty;
    } out_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] rank;
    } entry_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic pop;
    } store_ctl_t;

endpackage

FILE: design/sipq_store.sv
// Entry store: ring buffer memory addressed by logical slot (0 is the head).
// Depends on sipq_pkg for entry_t and store_ctl_t.
module sipq_store import sipq_pkg::*; #(
    parameter int CAPACITY = 16,
    parameter int AW       = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  store_ctl_t    ctl,
    input  logic [AW-1:0] rd_idx,
    input  logic [AW-1:0] wr_idx,
    input  entry_t        wr_data,
    output entry_t        rd_data
);

    localparam logic [AW:0] CAP = (AW+1)'(CAPACITY);

    entry_t        mem [CAPACITY];
    entry_t        rd_data_reg;
    logic [AW-1:0] head_reg;
    logic [AW-1:0] head_next;
    logic [AW-1:0] rd_phys;
    logic [AW-1:0] wr_phys;

    function automatic logic [AW-1:0] to_phys(input logic [AW-1:0] head,
                                              input logic [AW-1:0] idx);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, idx};
        if (sum >= CAP)
        begin
            sum = sum - CAP;
        end
        return sum[AW-1:0];
    endfunction

    assign rd_phys = to_phys(head_reg, rd_idx);
    assign wr_phys = to_phys(head_reg, wr_idx);
    // advance the head past the removed entry
    assign head_next = to_phys(head_reg, AW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
        end
        else if (ctl.pop)
        begin
            head_reg <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_phys] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_phys];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/sorted_insert_priority_queue.sv
// Sorted-insert priority queue, entries in one ring-buffer memory.
// Dequeue reads the head, then pops it and forms the result. Enqueue into an empty queue
// and any rejected item finish in the idle state; otherwise an enqueue walks from the
// tail, one memory read-and-shift per cycle through the single read port.
// Result appears in the cycle after the last step, strobed by done for one cycle.
// Reset clears the count, head pointer and sequencer; memory contents stay undefined.
`include "sorted_insert_priority_queue_assert.svh"
module sorted_insert_priority_queue import sipq_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  in_item_t  item,
    output logic      busy,
    output logic      done,
    output out_item_t result
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_POP   = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_PLACE = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] k_reg, k_next;
    entry_t        new_reg, new_next;
    logic          done_reg, done_next;
    out_item_t     result_reg, result_next;

    store_ctl_t    ctl;
    logic [AW-1:0] rd_idx;
    logic [AW-1:0] wr_idx;
    entry_t        wr_data;
    entry_t        rd_data;
    entry_t        in_entry;
    logic          shift;

    function automatic out_item_t pack_result(input logic ok,
                                              input logic signed [DATA_W-1:0] removed,
                                              input logic [CW-1:0] cnt);
        out_item_t       r;
        logic [CW+COUNT_W-1:0] cnt_ext;
        cnt_ext         = {{COUNT_W{1'b0}}, cnt};
        r.done_ok       = ok;
        r.removed_value = removed;
        r.entry_count   = cnt_ext[COUNT_W-1:0];
        r.is_empty      = (cnt == '0);
        return r;
    endfunction

    sipq_store #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .rd_idx  (rd_idx),
        .wr_idx  (wr_idx),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    assign in_entry.value = item.item_value;
    assign in_entry.rank  = item.item_rank;

    // Walking back from the tail: slots past the head move while their rank is not below
    // the new one; the head moves only for a strictly smaller new rank.
    assign shift = (k_reg == '0) ? ($signed(new_reg.rank) < $signed(rd_data.rank))
                                 : !($signed(rd_data.rank) < $signed(new_reg.rank));

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        k_next      = k_reg;
        new_next    = new_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        ctl         = '0;
        rd_idx      = '0;
        wr_idx      = '0;
        wr_data     = new_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (item.op == OP_DEQ)
                    begin
                        if (count_reg == '0)
                        begin
                            done_next   = 1'b1;
                            result_next = pack_result(1'b0, '0, count_reg);
                        end
                        else
                        begin
                            ctl.rd_en  = 1'b1;
                            state_next = S_POP;
                        end
                    end
                    else if (count_reg == CAP_COUNT)
                    begin
                        done_next   = 1'b1;
                        result_next = pack_result(1'b0, '0, count_reg);
                    end
                    else if (count_reg == '0)
                    begin
                        ctl.wr_en   = 1'b1;
                        wr_data     = in_entry;
                        count_next  = CW'(1);
                        done_next   = 1'b1;
                        result_next = pack_result(1'b1, '0, CW'(1));
                    end
                    else
                    begin
                        new_next   = in_entry;
                        ctl.rd_en  = 1'b1;
                        rd_idx     = AW'(count_reg - CW'(1));
                        k_next     = AW'(count_reg - CW'(1));
                        state_next = S_SCAN;
                    end
                end
            end
            S_POP:
            begin
                ctl.pop     = 1'b1;
                count_next  = count_reg - CW'(1);
                done_next   = 1'b1;
                result_next = pack_result(1'b1, rd_data.value, count_reg - CW'(1));
                state_next  = S_IDLE;
            end
            S_SCAN:
            begin
                ctl.wr_en = 1'b1;
                wr_idx    = k_reg + AW'(1);
                if (shift)
                begin
                    wr_data = rd_data;
                    if (k_reg == '0)
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        ctl.rd_en = 1'b1;
                        rd_idx    = k_reg - AW'(1);
                        k_next    = k_reg - AW'(1);
                    end
                end
                else
                begin
                    count_next  = count_reg + CW'(1);
                    done_next   = 1'b1;
                    result_next = pack_result(1'b1, '0, count_reg + CW'(1));
                    state_next  = S_IDLE;
                end
            end
            S_PLACE:
            begin
                // the old head has moved to slot 1; the new entry takes the head
                ctl.wr_en   = 1'b1;
                wr_idx      = '0;
                count_next  = count_reg + CW'(1);
                done_next   = 1'b1;
                result_next = pack_result(1'b1, '0, count_reg + CW'(1));
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg      <= k_next;
        new_reg    <= new_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    `SIPQ_ASSERT(a_count_bound, count_reg <= CAP_COUNT, "entry count above capacity")
    `SIPQ_IMPLY(a_no_same_slot, ctl.wr_en && ctl.rd_en, wr_idx != rd_idx, "read and write hit one slot")
    `SIPQ_IMPLY(a_pop_nonempty, ctl.pop, count_reg != '0, "pop from an empty queue")
    `SIPQ_IMPLY(a_scan_in_range, state_reg == S_SCAN, CW'(k_reg) < count_reg, "scan index past the tail")

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Testbench for the sorted-insert priority queue: drives enqueue and dequeue items
// through the start/busy handshake and checks each strobed result against a shadow queue.
// Depends on sipq_pkg and the sorted_insert_priority_queue top level.
module testbench;
    import sipq_pkg::*;

    localparam int CAPACITY     = 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_CYCLES = 40;

    localparam logic signed [DATA_W-1:0] RANK_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] RANK_MAX = 32'sh7fff_ffff;

    logic      clk;
    logic      rst_n;
    logic      start;
    in_item_t  item;
    logic      busy;
    logic      done;
    out_item_t result;

    sorted_insert_priority_queue #(.CAPACITY(CAPACITY)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    // Shadow copy of the queue contents, head at index 0
    entry_t    shadow_entries [CAPACITY];
    int        shadow_count;
    out_item_t expected_outcomes [$];
    out_item_t oldest_outcome;

    int     error_count;
    int     items_sent;
    int     results_checked;
    int     rejected_enqueues;
    int     empty_dequeues;
    int     head_ties;
    int     times_full;
    int     burst_left;
    bit     gaps_on;
    longint cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report_error(input string msg);
        error_count++;
        $display("[%0t] MISMATCH %0d: %s", $realtime, error_count, msg);
    endtask

    // Apply one item to the shadow queue and return the outcome it must produce
    function automatic out_item_t shadow_step(input in_item_t it);
        out_item_t outcome;
        int        pos;
        int        i;
        outcome = '0;
        if (it.op == OP_ENQ) begin
            if (shadow_count < CAPACITY) begin
                if (shadow_count == 0 || $signed(it.item_rank) < $signed(shadow_entries[0].rank))
                begin
                    pos = 0;
                end
                else
                begin
                    if ($signed(it.item_rank) == $signed(shadow_entries[0].rank))
                        head_ties++;
                    pos = 1;
                    while (pos < shadow_count &&
                           $signed(shadow_entries[pos].rank) < $signed(it.item_rank))
                        pos++;
                end
                for (i = shadow_count; i > pos; i--)
                    shadow_entries[i] = shadow_entries[i-1];
                shadow_entries[pos].value = it.item_value;
                shadow_entries[pos].rank  = it.item_rank;
                shadow_count++;
                if (shadow_count == CAPACITY)
                    times_full++;
                outcome.done_ok = 1'b1;
            end
            else
            begin
                rejected_enqueues++;
            end
        end
        else
        begin
            if (shadow_count != 0) begin
                outcome.removed_value = shadow_entries[0].value;
                for (i = 1; i < shadow_count; i++)
                    shadow_entries[i-1] = shadow_entries[i];
                shadow_count--;
                outcome.done_ok = 1'b1;
            end
            else
            begin
                empty_dequeues++;
            end
        end
        outcome.entry_count = shadow_count[COUNT_W-1:0];
        outcome.is_empty    = (shadow_count == 0);
        return outcome;
    endfunction

    function automatic in_item_t make_item(input logic op,
                                           input logic signed [DATA_W-1:0] value,
                                           input logic signed [DATA_W-1:0] rank);
        in_item_t it;
        it.op         = op;
        it.item_value = value;
        it.item_rank  = rank;
        return it;
    endfunction

    // Mostly narrow ranks so that ties are common; some extremes and full-width values
    function automatic logic signed [DATA_W-1:0] random_rank();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            return $signed(32'($urandom_range(0, 7))) - 4;
        else if (pick < 7)
        begin
            case ($urandom_range(0, 5))
                0: return RANK_MIN;
                1: return RANK_MAX;
                2: return RANK_MIN + 1;
                3: return RANK_MAX - 1;
                4: return 0;
                default: return -1;
            endcase
        end
        return $signed($urandom());
    endfunction

    // Present one item and hold it until the block takes it
    task automatic send_item(input in_item_t it);
        int gap;
        if (gaps_on && burst_left == 0) begin
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_outcomes.push_back(shadow_step(it));
        items_sent++;
    endtask

    task automatic send_enqueue(input logic signed [DATA_W-1:0] value,
                                input logic signed [DATA_W-1:0] rank);
        send_item(make_item(OP_ENQ, value, rank));
    endtask

    task automatic send_dequeue();
        // value and rank are don't-care on dequeue; scramble them anyway
        send_item(make_item(OP_DEQ, $signed($urandom()), $signed($urandom())));
    endtask

    task automatic test_empty_and_extremes();
        send_dequeue();
        send_enqueue(RANK_MAX, RANK_MAX);
        send_enqueue(RANK_MIN, RANK_MIN);
        send_enqueue(0, 0);
        send_enqueue(-1, -1);
        send_enqueue(32'sh5555_aaaa, 32'sh2aaa_5555);
        repeat (5) send_dequeue();
        send_dequeue();
    endtask

    task automatic test_equal_priority();
        send_enqueue(32'sh0000_00a1, 5);
        send_enqueue(32'sh0000_00b2, 5);
        send_enqueue(32'sh0000_00c3, 5);
        send_enqueue(32'sh0000_00d4, 3);
        send_enqueue(32'sh0000_00e5, 5);
        send_enqueue(32'sh0000_00f6, 4);
        repeat (6) send_dequeue();
    endtask

    // Fill to capacity, push past it, then drain past empty
    task automatic test_fill_and_drain(input int rounds);
        int r;
        for (r = 0; r < rounds; r++) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            while (shadow_count < CAPACITY) begin
                if ($urandom_range(0, 4) == 0)
                    send_dequeue();
                else
                    send_enqueue($signed($urandom()), random_rank());
            end
            repeat ($urandom_range(1, 3)) send_enqueue($signed($urandom()), random_rank());
            while (shadow_count > 0) begin
                if ($urandom_range(0, 5) == 0)
                    send_enqueue($signed($urandom()), random_rank());
                else
                    send_dequeue();
            end
            repeat ($urandom_range(1, 2)) send_dequeue();
        end
        gaps_on = 1'b1;
    endtask

    // Random traffic steered towards a fill level that wanders
    task automatic test_random_mix(input int count);
        int n;
        int target;
        bit do_enq;
        target = CAPACITY / 2;
        for (n = 0; n < count; n++) begin
            if (n % 50 == 0) begin
                target  = $urandom_range(0, CAPACITY + 2);
                gaps_on = ($urandom_range(0, 4) != 0);
            end
            if (shadow_count < target)
                do_enq = ($urandom_range(0, 3) != 0);
            else
                do_enq = ($urandom_range(0, 3) == 0);
            if (do_enq)
                send_enqueue($signed($urandom()), random_rank());
            else
                send_dequeue();
        end
        gaps_on = 1'b1;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done) begin
            results_checked++;
            if (expected_outcomes.size() == 0)
            begin
                report_error($sformatf("result %0d with nothing outstanding", results_checked));
            end
            else
            begin
                oldest_outcome = expected_outcomes.pop_front();
                if (result.done_ok !== oldest_outcome.done_ok)
                    report_error($sformatf("result %0d done_ok got %0b expected %0b",
                        results_checked, result.done_ok, oldest_outcome.done_ok));
                if (result.removed_value !== oldest_outcome.removed_value)
                    report_error($sformatf("result %0d removed_value got %0d expected %0d",
                        results_checked, result.removed_value, oldest_outcome.removed_value));
                if (result.entry_count !== oldest_outcome.entry_count)
                    report_error($sformatf("result %0d entry_count got %0d expected %0d",
                        results_checked, result.entry_count, oldest_outcome.entry_count));
                if (result.is_empty !== oldest_outcome.is_empty)
                    report_error($sformatf("result %0d is_empty got %0b expected %0b",
                        results_checked, result.is_empty, oldest_outcome.is_empty));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycle_count, expected_outcomes.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        item          = '0;
        shadow_count  = 0;
        burst_left    = 0;
        gaps_on       = 1'b1;
        cycle_count   = 0;
        for (int i = 0; i < CAPACITY; i++)
            shadow_entries[i] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_extremes();
        test_equal_priority();
        test_fill_and_drain(16);
        test_random_mix(550);

        start <= 1'b0;
        while (expected_outcomes.size() != 0)
            @(posedge clk);
        // hold a while longer to catch any stray strobe
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d items and %0d results in %0d cycles, queue full %0d times.",
                 items_sent, results_checked, cycle_count, times_full);
        $display("Rejected enqueues %0d, empty dequeues %0d, ties with the head %0d.",
                 rejected_enqueues, empty_dequeues, head_ties);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
